>>> src/qdq_pkg.sv
// Shared types and constants for the symmetric quantize/dequantize block.
// Used by the channel interfaces and by the top level; depends on nothing.
package qdq_pkg;

  typedef enum logic [2:0] {
    MODE_QUANT_I8   = 3'd0,
    MODE_QUANT_I4   = 3'd1,
    MODE_DEQUANT_I8 = 3'd2,
    MODE_DEQUANT_I4 = 3'd3,
    MODE_MEASURE_I8 = 3'd4,
    MODE_MEASURE_I4 = 3'd5
  } mode_t;

  // Register index is taken from paddr[2].
  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_SCALE      = 1'b0;
  localparam logic        REG_QUANT_GAIN = 1'b1;

  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [7:0]  LIM_I8    = 8'd127;
  localparam logic [7:0]  LIM_I4    = 8'd7;
  localparam logic [63:0] ROUND_Q32 = 64'h0000_0000_8000_0000;

  // Rounding offsets (divisor / 2) for the measured scale.
  localparam logic [31:0] HALF_127 = 32'd63;
  localparam logic [31:0] HALF_7   = 32'd3;

  // Exact reciprocals: floor(n * RECIP / 2^SHIFT) == floor(n / d) for every n below 2^32.
  localparam logic [32:0] RECIP_127 = 33'd4328785937;
  localparam int unsigned SHIFT_127 = 39;
  localparam logic [32:0] RECIP_7   = 33'd4908534053;
  localparam int unsigned SHIFT_7   = 35;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
    logic [7:0]         code;
    logic [1:0]         count;
    logic               last;
  } s1_t;

  typedef struct packed {
    mode_t              mode;
    logic [31:0]        mag;
    logic               neg;
    logic signed [47:0] deq0;
    logic signed [47:0] deq1;
    logic [1:0]         count;
    logic               last;
  } s2_t;

  typedef struct packed {
    mode_t              mode;
    logic [63:0]        prod;
    logic [31:0]        num;
    logic               zero;
    logic               neg;
    logic signed [47:0] deq0;
    logic signed [47:0] deq1;
    logic [1:0]         count;
    logic               last;
  } s3_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         q;
    logic [64:0]        mprod;
    logic               zero;
    logic signed [47:0] deq0;
    logic signed [47:0] deq1;
    logic [1:0]         count;
    logic               last;
  } s4_t;

  typedef struct packed {
    logic [7:0]         code;
    logic signed [47:0] value;
    logic               last;
  } res_t;

endpackage

>>> src/qdq_item_if.sv
// Input channel of the quantize/dequantize block: valid/ready plus one sample.
// Depends on qdq_pkg.
interface qdq_item_if import qdq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] in_value;
  logic [7:0]         in_code;
  logic [1:0]         in_count;
  logic               in_last;

  modport source (output valid, mode, in_value, in_code, in_count, in_last, input ready);
  modport sink   (input valid, mode, in_value, in_code, in_count, in_last, output ready);
endinterface

>>> src/qdq_result_if.sv
// Result channel of the quantize/dequantize block: valid/ready plus one result.
// Depends on qdq_pkg.
interface qdq_result_if import qdq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [7:0]         out_code;
  logic signed [47:0] out_value;
  logic               out_last;

  modport source (output valid, out_code, out_value, out_last, input ready);
  modport sink   (input valid, out_code, out_value, out_last, output ready);
endinterface

>>> src/symmetric_quantize_dequantize.sv
// Symmetric int8/int4 quantizer, dequantizer and scale measurement in Q16.16.
// The block takes one item per cycle through a five-register pipeline (input register,
// magnitude and dequantize multiply, gain multiply and running maximum, rounding and
// reciprocal multiply, result register); each result waits in the result register until
// it is taken. While a result waits, the input keeps accepting until every stage in front
// of the result register holds an item. An int4 dequantize item with two nibbles holds
// the result register for two transactions; apart from stalls on the result side, that
// is the only case that slows the input.
// Depends on qdq_pkg, qdq_item_if and qdq_result_if.
module symmetric_quantize_dequantize import qdq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  qdq_item_if.sink           item,
  qdq_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] scale;
  logic [31:0] quant_gain;
  logic [31:0] running_max;
  logic [3:0]  held_nibble;
  logic        nibble_pending;

  logic s1_valid, s2_valid, s3_valid, s4_valid;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  s4_t  s4;
  logic [1:0] o_left;
  res_t res0, res1;

  logic ready1, ready2, ready3, ready4, ready5;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANT_GAIN) ? quant_gain : scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= ONE_Q16;
      quant_gain <= ONE_Q16;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SCALE) begin
        scale <= pwdata;
      end else begin
        quant_gain <= pwdata;
      end
    end
  end

  // Stage readiness: a stage can load when empty or when its item moves on.
  assign ready5 = (o_left == 2'd0) || (o_left == 2'd1 && result.ready);
  assign ready4 = !s4_valid || ready5;
  assign ready3 = !s3_valid || ready4;
  assign ready2 = !s2_valid || ready3;
  assign ready1 = !s1_valid || ready2;
  assign item.ready = ready1;

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && item.valid) begin
      s1.mode  <= mode_t'(item.mode);
      s1.value <= item.in_value;
      s1.code  <= item.in_code;
      s1.count <= item.in_count;
      s1.last  <= item.in_last;
    end
  end

  // Stage 2: magnitude of the sample and dequantize products.
  logic [31:0]        raw1;
  logic [7:0]         c0_code, c1_code;
  logic signed [40:0] p0, p1;

  always_comb begin
    raw1    = s1.value;
    c0_code = (s1.mode == MODE_DEQUANT_I4) ? {{4{s1.code[3]}}, s1.code[3:0]} : s1.code;
    c1_code = {{4{s1.code[7]}}, s1.code[7:4]};
    p0      = $signed(c0_code) * $signed({1'b0, scale});
    p1      = $signed(c1_code) * $signed({1'b0, scale});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2.mode  <= s1.mode;
      s2.neg   <= raw1[31];
      s2.mag   <= raw1[31] ? (32'd0 - raw1) : raw1;
      s2.deq0  <= {{7{p0[40]}}, p0};
      s2.deq1  <= {{7{p1[40]}}, p1};
      s2.count <= s1.count;
      s2.last  <= s1.last;
    end
  end

  // Stage 3: gain multiply for quantize, running maximum for measure.
  logic [31:0] new_max;
  logic [63:0] gain_prod;
  logic        s2_measure;

  always_comb begin
    s2_measure = (s2.mode == MODE_MEASURE_I8) || (s2.mode == MODE_MEASURE_I4);
    new_max    = (s2.mag > running_max) ? s2.mag : running_max;
    gain_prod  = s2.mag * quant_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= 32'd0;
    end else if (s2_valid && ready3 && s2_measure) begin
      running_max <= s2.last ? 32'd0 : new_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      s3.mode  <= s2.mode;
      s3.prod  <= gain_prod;
      s3.num   <= new_max + ((s2.mode == MODE_MEASURE_I8) ? HALF_127 : HALF_7);
      s3.zero  <= (new_max == 32'd0);
      s3.neg   <= s2.neg;
      s3.deq0  <= s2.deq0;
      s3.deq1  <= s2.deq1;
      s3.count <= s2.count;
      s3.last  <= s2.last;
    end
  end

  // Stage 4: round and saturate the code, reciprocal multiply for the scale.
  logic [63:0] rounded;
  logic [31:0] q_full;
  logic [7:0]  q_lim;
  logic [7:0]  q_sat;
  logic [32:0] recip;
  logic [64:0] meas_prod;

  always_comb begin
    rounded   = s3.prod + ROUND_Q32;
    // The carry out of the rounding add means the code is far above any limit.
    q_full    = rounded[63:32];
    q_lim     = (s3.mode == MODE_QUANT_I8) ? LIM_I8 : LIM_I4;
    q_sat     = ((s3.prod > rounded) || (q_full > {24'd0, q_lim})) ? q_lim : q_full[7:0];
    recip     = (s3.mode == MODE_MEASURE_I8) ? RECIP_127 : RECIP_7;
    meas_prod = s3.num * recip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (ready4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && s3_valid) begin
      s4.mode  <= s3.mode;
      s4.q     <= s3.neg ? (8'd0 - q_sat) : q_sat;
      s4.mprod <= meas_prod;
      s4.zero  <= s3.zero;
      s4.deq0  <= s3.deq0;
      s4.deq1  <= s3.deq1;
      s4.count <= s3.count;
      s4.last  <= s3.last;
    end
  end

  // Stage 5: form the results and pack int4 codes.
  res_t       r0, r1;
  logic [1:0] nres;
  logic       take_nibble;
  logic       drop_nibble;
  logic [31:0] meas_q;

  always_comb begin
    r0          = '0;
    r1          = '0;
    nres        = 2'd0;
    take_nibble = 1'b0;
    drop_nibble = 1'b0;
    meas_q      = (s4.mode == MODE_MEASURE_I8) ? 32'(s4.mprod >> SHIFT_127)
                                               : 32'(s4.mprod >> SHIFT_7);
    case (s4.mode)
      MODE_QUANT_I8: begin
        r0.code = s4.q;
        r0.last = s4.last;
        nres    = 2'd1;
      end
      MODE_QUANT_I4: begin
        if (nibble_pending) begin
          r0.code     = {s4.q[3:0], held_nibble};
          r0.last     = s4.last;
          nres        = 2'd1;
          drop_nibble = 1'b1;
        end else if (s4.last) begin
          r0.code = {4'd0, s4.q[3:0]};
          r0.last = 1'b1;
          nres    = 2'd1;
        end else begin
          take_nibble = 1'b1;
        end
      end
      MODE_DEQUANT_I8: begin
        r0.value = s4.deq0;
        r0.last  = s4.last;
        nres     = 2'd1;
      end
      MODE_DEQUANT_I4: begin
        r0.value = s4.deq0;
        // A count of three is treated as two, and zero as one.
        if (s4.count[1]) begin
          r1.value = s4.deq1;
          r1.last  = s4.last;
          nres     = 2'd2;
        end else begin
          r0.last = s4.last;
          nres    = 2'd1;
        end
      end
      MODE_MEASURE_I8, MODE_MEASURE_I4: begin
        if (s4.last) begin
          r0.value = s4.zero ? {16'd0, ONE_Q16} : {16'd0, meas_q};
          r0.last  = 1'b1;
          nres     = 2'd1;
        end
      end
      default: begin
        nres = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_nibble    <= 4'd0;
      nibble_pending <= 1'b0;
    end else if (s4_valid && ready5) begin
      if (drop_nibble) begin
        held_nibble    <= 4'd0;
        nibble_pending <= 1'b0;
      end else if (take_nibble) begin
        held_nibble    <= s4.q[3:0];
        nibble_pending <= 1'b1;
      end
    end
  end

  // Result register: up to two results, the second shifts forward after the first.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_left <= 2'd0;
    end else if (ready5) begin
      o_left <= s4_valid ? nres : 2'd0;
    end else if (result.ready) begin
      o_left <= 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      if (s4_valid) begin
        res0 <= r0;
        res1 <= r1;
      end
    end else if (result.ready) begin
      res0 <= res1;
    end
  end

  assign result.valid     = (o_left != 2'd0);
  assign result.out_code  = res0.code;
  assign result.out_value = res0.value;
  assign result.out_last  = res0.last;

endmodule

>>> dv/tb_symmetric_quantize_dequantize.sv
`timescale 1ns / 100ps
// Self-checking testbench for symmetric_quantize_dequantize: random valid/ready traffic
// on both channels, APB register settings per phase, results checked in order.
// Depends on qdq_pkg, qdq_item_if, qdq_result_if and the top level.
module tb_symmetric_quantize_dequantize import qdq_pkg::*;;

  localparam logic [2:0]  MODE_RSVD6      = 3'd6;
  localparam logic [2:0]  MODE_RSVD7      = 3'd7;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 178;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned MAX_PRINTED     = 40;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [7:0]  code;
    logic [1:0]  count;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [47:0] value;
    logic        last;
  } qdq_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  qdq_item_if   samp_if ();
  qdq_result_if res_if ();

  symmetric_quantize_dequantize dut (
    .clk     (clk),
    .rst     (rst),
    .item    (samp_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: register copies plus the block's internal state.
  logic [31:0] scale_cfg;
  logic [31:0] gain_cfg;
  logic [3:0]  held_nib;
  logic        nib_held;
  logic [31:0] run_max;

  sample_t     pending_samples[$];
  qdq_result_t due_results[$];

  bit          in_fire = 1'b0;
  bit          res_fire = 1'b0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 1;
  int unsigned samples_by_mode[8];
  sample_t     cur;
  sample_t     seen;
  qdq_result_t want;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 99) < 4) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Magnitude times gain in Q32.32, rounded half away from zero, saturated, signed.
  function automatic logic [7:0] quantize_code(input logic [31:0] raw, input logic [7:0] lim);
    logic        neg;
    logic [31:0] mag;
    logic [63:0] q;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    q = ({32'd0, mag} * {32'd0, gain_cfg} + 64'h0000_0000_8000_0000) >> 32;
    if (q > {56'd0, lim}) q = {56'd0, lim};
    return neg ? (8'd0 - q[7:0]) : q[7:0];
  endfunction

  function automatic logic [47:0] dequant_value(input logic signed [7:0] c);
    logic signed [63:0] cs;
    logic signed [63:0] ss;
    logic signed [63:0] p;
    cs = c;
    ss = {32'd0, scale_cfg};
    p = cs * ss;
    return p[47:0];
  endfunction

  task automatic queue_result(input logic [7:0] code, input logic [47:0] value,
                              input logic last);
    due_results.push_back('{code: code, value: value, last: last});
  endtask

  task automatic derive_results(input sample_t s);
    logic [7:0]  q;
    logic [31:0] mag;
    logic [63:0] div;
    logic [63:0] meas;
    case (s.mode)
      MODE_QUANT_I8: queue_result(quantize_code(s.value, LIM_I8), 48'd0, s.last);
      MODE_QUANT_I4: begin
        q = quantize_code(s.value, LIM_I4);
        if (nib_held) begin
          queue_result({q[3:0], held_nib}, 48'd0, s.last);
          nib_held = 1'b0;
          held_nib = 4'd0;
        end else if (s.last) begin
          queue_result({4'd0, q[3:0]}, 48'd0, 1'b1);
        end else begin
          held_nib = q[3:0];
          nib_held = 1'b1;
        end
      end
      MODE_DEQUANT_I8: queue_result(8'd0, dequant_value($signed(s.code)), s.last);
      MODE_DEQUANT_I4: begin
        // A count of zero behaves as one nibble, three as two.
        if (s.count >= 2'd2) begin
          queue_result(8'd0, dequant_value($signed(s.code[3:0])), 1'b0);
          queue_result(8'd0, dequant_value($signed(s.code[7:4])), s.last);
        end else begin
          queue_result(8'd0, dequant_value($signed(s.code[3:0])), s.last);
        end
      end
      MODE_MEASURE_I8, MODE_MEASURE_I4: begin
        mag = s.value[31] ? (32'd0 - s.value) : s.value;
        if (mag > run_max) run_max = mag;
        if (s.last) begin
          div = (s.mode == MODE_MEASURE_I8) ? 64'd127 : 64'd7;
          meas = (run_max == 32'd0) ? {32'd0, ONE_Q16} : ({32'd0, run_max} + div / 2) / div;
          run_max = 32'd0;
          queue_result(8'd0, meas[47:0], 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // Sample driver: holds each transaction until taken, then waits its drawn gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (!samp_if.valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          samp_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          cur = pending_samples.pop_front();
          samp_if.mode     <= cur.mode;
          samp_if.in_value <= cur.value;
          samp_if.in_code  <= cur.code;
          samp_if.in_count <= cur.count;
          samp_if.in_last  <= cur.last;
          samp_if.valid    <= 1'b1;
          send_gap = draw_gap(send_calm);
        end else begin
          samp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: after each transaction, holds ready low for a randomly drawn gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (res_fire) take_gap = draw_gap(take_calm);
      if (take_gap > 0) begin
        take_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on accepted samples, checks accepted results, runs the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      in_fire  <= samp_if.valid && samp_if.ready;
      res_fire <= res_if.valid && res_if.ready;
      if (samp_if.valid && samp_if.ready) begin
        seen = '{mode: samp_if.mode, value: samp_if.in_value, code: samp_if.in_code,
                 count: samp_if.in_count, last: samp_if.in_last};
        samples_by_mode[samp_if.mode]++;
        derive_results(seen);
      end
      if (res_if.valid && res_if.ready) begin
        results_checked++;
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result code %h value %h last %b",
                                 res_if.out_code, res_if.out_value, res_if.out_last));
        end else begin
          want = due_results.pop_front();
          if (res_if.out_code !== want.code)
            log_mismatch($sformatf("out_code %h, expected %h", res_if.out_code, want.code));
          if (res_if.out_value !== want.value)
            log_mismatch($sformatf("out_value %h, expected %h", res_if.out_value, want.value));
          if (res_if.out_last !== want.last)
            log_mismatch($sformatf("out_last %b, expected %b", res_if.out_last, want.last));
        end
      end
      if ((samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, due_results.size());
        $display("tb_symmetric_quantize_dequantize: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SCALE) scale_cfg = val;
    else gain_cfg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every sample is taken and every result is back, then lets any
  // no-result item still in the pipeline drain out.
  task automatic settle();
    while (pending_samples.size() != 0 || samp_if.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_sample(input logic [2:0] mode, input logic [31:0] value,
                            input logic [7:0] code, input logic [1:0] count,
                            input logic last);
    pending_samples.push_back('{mode: mode, value: value, code: code, count: count,
                                last: last});
  endtask

  // Mostly values near multiples of the scale, so codes spread over the whole range
  // and a few saturate; the rest are extremes or raw random words.
  function automatic logic [31:0] draw_sample(input int lim);
    int                 steps;
    logic signed [63:0] step_sz;
    logic signed [63:0] v;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
      default: begin
        steps = int'($urandom_range(0, 2 * lim + 4)) - lim - 2;
        step_sz = {32'd0, scale_cfg};
        v = step_sz * steps + $signed({32'd0, $urandom_range(0, scale_cfg)}) - (step_sz >>> 1);
        return v[31:0];
      end
    endcase
  endfunction

  task automatic build_random_phase(input int unsigned n_items);
    int unsigned added;
    int unsigned len;
    int unsigned k;
    logic [2:0]  m;
    int          lim;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        // Noise: any mode, any field, random last.
        m = 3'($urandom_range(0, 7));
        add_sample(m, $urandom(), 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
        if (m <= MODE_MEASURE_I4) added++;
      end else begin
        // One tensor of a single mode, last on its final element.
        m = 3'($urandom_range(0, 5));
        lim = (m == MODE_QUANT_I8 || m == MODE_MEASURE_I8) ? 127 : 7;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          add_sample(m, draw_sample(lim), 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), k == len - 1);
          added++;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] sc;
    logic [31:0] gn;
    logic [63:0] recip;
    int unsigned ph;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    samp_if.valid    = 1'b0;
    samp_if.mode     = MODE_QUANT_I8;
    samp_if.in_value = '0;
    samp_if.in_code  = '0;
    samp_if.in_count = '0;
    samp_if.in_last  = 1'b0;
    res_if.ready     = 1'b0;
    scale_cfg        = ONE_Q16;
    gain_cfg         = ONE_Q16;
    held_nib         = 4'd0;
    nib_held         = 1'b0;
    run_max          = 32'd0;
    foreach (samples_by_mode[i]) samples_by_mode[i] = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values (scale and gain both 1.0).
    add_sample(MODE_QUANT_I8, 32'h7FFF_FFFF, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_QUANT_I8, 32'h8000_0000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_QUANT_I8, 32'h0001_8000, 8'h00, 2'd0, 1'b0);   // 1.5 rounds to 2
    add_sample(MODE_QUANT_I8, 32'hFFFE_8000, 8'h00, 2'd0, 1'b0);   // -1.5 rounds to -2
    add_sample(MODE_QUANT_I8, 32'h0000_0000, 8'h00, 2'd0, 1'b1);
    add_sample(MODE_QUANT_I4, 32'h0003_0000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_DEQUANT_I8, 32'h0, 8'h80, 2'd0, 1'b0);         // held nibble survives
    add_sample(MODE_QUANT_I4, 32'hFFFD_8000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_QUANT_I4, 32'h7FFF_FFFF, 8'h00, 2'd0, 1'b1);   // odd element alone
    add_sample(MODE_QUANT_I4, 32'h8000_0000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_QUANT_I4, 32'h0000_0000, 8'h00, 2'd0, 1'b1);
    add_sample(MODE_DEQUANT_I8, 32'h0, 8'h7F, 2'd0, 1'b0);
    add_sample(MODE_DEQUANT_I8, 32'h0, 8'hFF, 2'd0, 1'b1);
    add_sample(MODE_DEQUANT_I4, 32'h0, 8'h8F, 2'd2, 1'b0);
    add_sample(MODE_DEQUANT_I4, 32'h0, 8'h7A, 2'd1, 1'b0);
    add_sample(MODE_DEQUANT_I4, 32'h0, 8'h21, 2'd0, 1'b0);
    add_sample(MODE_DEQUANT_I4, 32'h0, 8'hF8, 2'd3, 1'b1);
    add_sample(MODE_MEASURE_I8, 32'h0064_0000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_QUANT_I8, 32'h0001_0000, 8'h00, 2'd0, 1'b0);   // running max survives
    add_sample(MODE_MEASURE_I8, 32'hFF9C_0000, 8'h00, 2'd0, 1'b0);
    add_sample(MODE_MEASURE_I8, 32'h8000_0000, 8'h00, 2'd0, 1'b1);
    add_sample(MODE_MEASURE_I4, 32'h0000_0000, 8'h00, 2'd0, 1'b1); // zero max gives 1.0
    add_sample(MODE_MEASURE_I4, 32'h0007_FFFF, 8'h00, 2'd0, 1'b1);
    add_sample(MODE_RSVD6, 32'hFFFF_FFFF, 8'hFF, 2'd3, 1'b1);
    add_sample(MODE_RSVD7, 32'h1234_5678, 8'h5A, 2'd2, 1'b1);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          sc = 32'd0;
          gn = 32'd0;
        end
        1: begin
          sc = 32'hFFFF_FFFF;
          gn = 32'hFFFF_FFFF;
        end
        PHASES - 1: begin
          sc = ONE_Q16;
          gn = ONE_Q16;
        end
        default: begin
          if (ph % 2 == 0) begin
            sc = $urandom();
            gn = $urandom();
          end else begin
            // Gain as the rounded reciprocal of the scale, as software would set it.
            sc = $urandom_range(32'h0000_0100, 32'h0004_0000);
            recip = (64'h1_0000_0000 + {32'd0, sc} / 2) / {32'd0, sc};
            gn = recip[31:0];
          end
        end
      endcase
      write_reg(REG_SCALE, sc);
      write_reg(REG_QUANT_GAIN, gn);
      settings_used++;
      build_random_phase(ITEMS_PER_PHASE);
      settle();
    end

    if (due_results.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    $display("Sent %0d samples: %0d quantize, %0d dequantize, %0d measure, %0d reserved mode.",
             samples_by_mode[0] + samples_by_mode[1] + samples_by_mode[2] +
             samples_by_mode[3] + samples_by_mode[4] + samples_by_mode[5] +
             samples_by_mode[6] + samples_by_mode[7],
             samples_by_mode[0] + samples_by_mode[1], samples_by_mode[2] + samples_by_mode[3],
             samples_by_mode[4] + samples_by_mode[5], samples_by_mode[6] + samples_by_mode[7]);
    $display("Checked %0d results under %0d register settings, %0d mismatches.",
             results_checked, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("tb_symmetric_quantize_dequantize: PASS");
    end else begin
      $display("tb_symmetric_quantize_dequantize: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/qdq_pkg.sv
src/qdq_item_if.sv
src/qdq_result_if.sv
src/symmetric_quantize_dequantize.sv
dv/tb_symmetric_quantize_dequantize.sv
